FILE: src/bulk_header_check_and_credit_core_defines.svh
// assertion helpers for the header check and credit core
// clocked on clk, held off while arst_n is low
`ifndef BULK_HEADER_CHECK_AND_CREDIT_CORE_DEFINES_SVH
`define BULK_HEADER_CHECK_AND_CREDIT_CORE_DEFINES_SVH

// same-cycle implication
`define BHCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BHCC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/bhcc_pkg.sv
package bhcc_pkg;

	localparam int unsigned VER_W  = 8;
	localparam int unsigned TYPE_W = 8;
	localparam int unsigned RSV_W  = 48;
	localparam int unsigned WORD_W = 64;
	localparam int unsigned LEN_W  = 32;
	localparam int unsigned CODE_W = 3;

	localparam logic [LEN_W-1:0] HDR_BYTES    = LEN_W'(24);
	// largest payload a send may carry: 2^32 - 1 - header
	localparam logic [LEN_W-1:0] MAX_SEND_LEN = {LEN_W{1'b1}} - HDR_BYTES;

	localparam logic [VER_W-1:0] VERSION_RST = VER_W'(1);

	localparam logic [TYPE_W-1:0] TY_START    = TYPE_W'(1);
	localparam logic [TYPE_W-1:0] TY_DATA     = TYPE_W'(2);
	localparam logic [TYPE_W-1:0] TY_COMPLETE = TYPE_W'(3);
	localparam logic [TYPE_W-1:0] TY_ABORT    = TYPE_W'(4);
	localparam logic [TYPE_W-1:0] TY_CREDIT   = TYPE_W'(5);

	localparam logic REQ_RX = 1'b0;
	localparam logic REQ_TX = 1'b1;

	typedef enum logic [CODE_W-1:0] {
		ST_OK      = 3'd0,
		ST_LOSS    = 3'd1,
		ST_INVAL   = 3'd2,
		ST_RANGE   = 3'd3,
		ST_EXHAUST = 3'd4
	} status_t;

	typedef enum logic [CODE_W-1:0] {
		EV_NONE     = 3'd0,
		EV_START    = 3'd1,
		EV_DATA     = 3'd2,
		EV_COMPLETE = 3'd3,
		EV_ABORT    = 3'd4,
		EV_CREDIT   = 3'd5,
		EV_SENT     = 3'd6
	} event_t;

endpackage

FILE: src/bhcc_ifs.sv
// request channel: received header or local send request
interface bhcc_hdr_if;
	import bhcc_pkg::*;

	logic                valid;
	logic                ready;
	logic                req_type;
	logic [VER_W-1:0]    version_byte;
	logic [TYPE_W-1:0]   msg_type;
	logic [RSV_W-1:0]    reserved_bytes;
	logic [WORD_W-1:0]   xfer_tag;
	logic [WORD_W-1:0]   value_word;
	logic [LEN_W-1:0]    byte_length;

	modport source (
		output valid, req_type, version_byte, msg_type, reserved_bytes,
		       xfer_tag, value_word, byte_length,
		input  ready
	);
	modport sink (
		input  valid, req_type, version_byte, msg_type, reserved_bytes,
		       xfer_tag, value_word, byte_length,
		output ready
	);
endinterface

// result channel
interface bhcc_res_if;
	import bhcc_pkg::*;

	logic                valid;
	logic                ready;
	logic [CODE_W-1:0]   status;
	logic [CODE_W-1:0]   event_res;
	logic [WORD_W-1:0]   result_word;
	logic [WORD_W-1:0]   available_credit;

	modport source (
		output valid, status, event_res, result_word, available_credit,
		input  ready
	);
	modport sink (
		input  valid, status, event_res, result_word, available_credit,
		output ready
	);
endinterface

FILE: src/bulk_header_check_and_credit_core.sv
// channel  | dir | word
// ---------+-----+------------------------------------------------------------
// hdr_in   | in  | req_type, version, type, reserved, transfer id, value, length
// res_out  | out | status, event, result word, available remote credit
// cfg      | in  | cfg_we / cfg_wdata, expected version byte
//
// one word accepted every cycle unless the pipeline stalls; a result is valid
// after the input and result registers; credit state updates as a word leaves s1
// arst_n clears credit counters, valids and sets expected version to 1
// a stalled result register holds its word; the input register still takes
// a new word when the result is being taken in the same cycle
`include "bulk_header_check_and_credit_core_defines.svh"

module bulk_header_check_and_credit_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bhcc_pkg::VER_W-1:0] cfg_wdata,
	bhcc_hdr_if.sink                  hdr_in,
	bhcc_res_if.source                res_out
);
	import bhcc_pkg::*;

	// configuration
	logic [VER_W-1:0] exp_version_q;

	// input register stage
	logic              valid_s1;
	logic              req_type_s1;
	logic [VER_W-1:0]  version_s1;
	logic [TYPE_W-1:0] msg_type_s1;
	logic [RSV_W-1:0]  reserved_s1;
	logic [WORD_W-1:0] tid_s1;
	logic [WORD_W-1:0] value_s1;
	logic [LEN_W-1:0]  blen_s1;

	// result register stage
	logic              valid_s2;
	status_t           status_s2;
	event_t            event_s2;
	logic [WORD_W-1:0] word_s2;
	logic [WORD_W-1:0] avail_s2;

	// credit state; avail_q tracks remote_limit - remote_used
	logic [WORD_W-1:0] local_limit_q, local_used_q;
	logic [WORD_W-1:0] remote_limit_q, remote_used_q;
	logic [WORD_W-1:0] avail_q;

	logic              adv_s1;
	logic              fire_s1;

	// next-state and result values from the logic between s1 and s2
	logic [WORD_W-1:0] local_limit_d, local_used_d;
	logic [WORD_W-1:0] remote_limit_d, remote_used_d, avail_d;
	status_t           status_d;
	event_t            event_d;
	logic [WORD_W-1:0] word_d;

	// decode
	logic              tid_nz, val_nz, plen_z, carry;
	logic              rules_ok, rules_range;
	logic              hdr_bad;
	logic [LEN_W-1:0]  plen;
	logic [WORD_W:0]   val_plus_len;
	logic [WORD_W:0]   grant_sum;

	// handshake: s1 moves on when the result register is free or being drained
	assign adv_s1       = !valid_s2 || res_out.ready;
	assign fire_s1      = valid_s1 && adv_s1;
	assign hdr_in.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_version_q <= VERSION_RST;
		end else if (cfg_we) begin
			exp_version_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr_in.ready) begin
			valid_s1 <= hdr_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_in.ready && hdr_in.valid) begin
			req_type_s1 <= hdr_in.req_type;
			version_s1  <= hdr_in.version_byte;
			msg_type_s1 <= hdr_in.msg_type;
			reserved_s1 <= hdr_in.reserved_bytes;
			tid_s1      <= hdr_in.xfer_tag;
			value_s1    <= hdr_in.value_word;
			blen_s1     <= hdr_in.byte_length;
		end
	end

	// field decode
	always_comb begin
		tid_nz       = (tid_s1 != '0);
		val_nz       = (value_s1 != '0);
		// receive length includes the header; only used once blen >= header
		plen         = (req_type_s1 == REQ_RX) ? (blen_s1 - HDR_BYTES) : blen_s1;
		plen_z       = (plen == '0);
		val_plus_len = {1'b0, value_s1} + {{(WORD_W + 1 - LEN_W){1'b0}}, plen};
		carry        = val_plus_len[WORD_W];
		hdr_bad      = (blen_s1 < HDR_BYTES) || (version_s1 != exp_version_q)
		               || (reserved_s1 != '0);
		grant_sum    = {1'b0, local_limit_q} + {1'b0, value_s1};
	end

	// per-type rules, shared by both directions
	always_comb begin
		rules_ok    = 1'b0;
		rules_range = 1'b0;
		case (msg_type_s1)
			TY_START: begin
				rules_ok = tid_nz && plen_z;
			end
			TY_DATA: begin
				rules_ok    = tid_nz && !plen_z && !carry;
				rules_range = tid_nz && !plen_z && carry;
			end
			TY_COMPLETE: begin
				rules_ok = tid_nz && !val_nz && plen_z;
			end
			TY_ABORT: begin
				rules_ok = tid_nz && !val_nz;
			end
			TY_CREDIT: begin
				rules_ok = !tid_nz && val_nz && plen_z;
			end
			default: begin
				rules_ok = 1'b0;
			end
		endcase
	end

	// status, event and state update
	always_comb begin
		status_d       = ST_OK;
		event_d        = EV_NONE;
		word_d         = value_s1;
		local_limit_d  = local_limit_q;
		local_used_d   = local_used_q;
		remote_limit_d = remote_limit_q;
		remote_used_d  = remote_used_q;
		avail_d        = avail_q;

		if (req_type_s1 == REQ_RX) begin
			if (hdr_bad || !rules_ok) begin
				status_d = ST_LOSS;
			end else if (msg_type_s1 == TY_DATA) begin
				// receiving data consumes one local credit
				if (local_used_q >= local_limit_q) begin
					status_d = ST_LOSS;
				end else begin
					local_used_d = local_used_q + WORD_W'(1);
					event_d      = EV_DATA;
				end
			end else if (msg_type_s1 == TY_CREDIT) begin
				// cumulative grant; a stale one is silently ignored
				if (value_s1 > remote_limit_q) begin
					word_d         = value_s1 - remote_limit_q;
					remote_limit_d = value_s1;
					avail_d        = (value_s1 > remote_used_q) ?
					                 (value_s1 - remote_used_q) : '0;
					event_d        = EV_CREDIT;
				end
			end else begin
				event_d = event_t'(msg_type_s1[CODE_W-1:0]);
			end
		end else begin
			if (blen_s1 > MAX_SEND_LEN) begin
				status_d = ST_RANGE;
			end else if (!rules_ok) begin
				status_d = rules_range ? ST_RANGE : ST_INVAL;
			end else if (msg_type_s1 == TY_DATA) begin
				if (avail_q == '0) begin
					status_d = ST_EXHAUST;
				end else begin
					remote_used_d = remote_used_q + WORD_W'(1);
					avail_d       = avail_q - WORD_W'(1);
					event_d       = EV_SENT;
				end
			end else if (msg_type_s1 == TY_CREDIT) begin
				// new local limit goes out on the wire
				if (grant_sum[WORD_W]) begin
					status_d = ST_RANGE;
				end else begin
					local_limit_d = grant_sum[WORD_W-1:0];
					word_d        = grant_sum[WORD_W-1:0];
					event_d       = EV_SENT;
				end
			end else begin
				event_d = EV_SENT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_limit_q  <= '0;
			local_used_q   <= '0;
			remote_limit_q <= '0;
			remote_used_q  <= '0;
			avail_q        <= '0;
		end else if (fire_s1) begin
			local_limit_q  <= local_limit_d;
			local_used_q   <= local_used_d;
			remote_limit_q <= remote_limit_d;
			remote_used_q  <= remote_used_d;
			avail_q        <= avail_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			status_s2 <= status_d;
			event_s2  <= event_d;
			word_s2   <= word_d;
			avail_s2  <= avail_d;
		end
	end

	assign res_out.valid            = valid_s2;
	assign res_out.status           = status_s2;
	assign res_out.event_res        = event_s2;
	assign res_out.result_word      = word_s2;
	assign res_out.available_credit = avail_s2;

	// credit bookkeeping and result invariants
	`BHCC_ASSERT_NOW(a_avail_track, 1'b1, avail_q == (remote_limit_q - remote_used_q),
		"available credit out of step with remote counters")
	`BHCC_ASSERT_NOW(a_remote_bound, 1'b1, remote_used_q <= remote_limit_q,
		"remote credit overdrawn")
	`BHCC_ASSERT_NOW(a_local_bound, 1'b1, local_used_q <= local_limit_q,
		"local credit overdrawn")
	`BHCC_ASSERT_NOW(a_err_no_event, valid_s2 && (status_s2 != ST_OK), event_s2 == EV_NONE,
		"error result carries an event")
	`BHCC_ASSERT_NXT(a_state_hold, !fire_s1,
		$stable(local_limit_q) && $stable(remote_limit_q) && $stable(avail_q),
		"credit state changed without a word")

endmodule
